FILE: src/mrm_pkg.sv
// ----------------------------------------------------------------------------
// mrm_pkg
// Shared types and fixed widths for the max/RMS error metrics block.
// ----------------------------------------------------------------------------
package mrm_pkg;

   // port width of every value field
   localparam int unsigned VAL_W = 32;
   // width of a square and of a sum of squares
   localparam int unsigned SQ_W = 64;
   // fraction bits of the Q16.16 relative error
   localparam int unsigned FRAC_W = 16;
   // 1.0 in Q16.16, floor of the relative error divisor
   localparam logic [VAL_W-1:0] ONE_Q16 = 32'h0001_0000;

   // status of one serial arithmetic unit
   typedef struct packed {
      logic busy;   // steps in progress
      logic done;   // one-cycle pulse, result valid from here on
   } unit_status_type;

endpackage

FILE: src/max_rms_error_metrics.sv
// An item not marked last runs the 32-step relative error divider, with the
// 16-step square multiplier squaring |d| beside it, then the multiplier again
// on the relative error before the next req_ready. An item marked last also runs
// the 64-step mean dividers and the 32-step square roots before rsp_valid.
// One item is processed at a time; a waiting result blocks new items only once
// the next set's result is ready to be presented.
// Reset (synchronous) clears all peaks, sums, the count and the saturation flag.
// ----------------------------------------------------------------------------
// max_rms_error_metrics
// Max and RMS of the absolute and relative error over a set of
// (sample, reference) pairs, one result per set on the item marked last.
// ----------------------------------------------------------------------------
module max_rms_error_metrics #(
   parameter int MAX_ELEMENTS = 1048576,
   parameter int VALUE_WIDTH  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_sample_value,
   input  logic [31:0] req_reference_value,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_max_abs_error,
   output logic [31:0] rsp_rms_abs_error,
   output logic [31:0] rsp_max_rel_error,
   output logic [31:0] rsp_rms_rel_error,
   output logic        rsp_sum_saturated
);

   localparam int VAL_W  = mrm_pkg::VAL_W;
   localparam int SQ_W   = mrm_pkg::SQ_W;
   localparam int FRAC_W = mrm_pkg::FRAC_W;
   localparam int EXT_W  = VAL_W + 2;
   localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_ABS,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_ACCUM,
      ST_MEAN_GO,
      ST_MEAN_WAIT,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_EMIT
   } state_type;

   state_type state_ff;

   // current item
   logic [EXT_W-1:0] s_ff;
   logic [EXT_W-1:0] r_ff;
   logic             last_ff;
   logic [EXT_W-1:0] diff_ff;
   logic [VAL_W-1:0] sabs_ff;
   logic             s_zero_ff;
   logic [VAL_W-1:0] ad_ff;
   logic [VAL_W-1:0] den_ff;
   logic [VAL_W-1:0] rel_ff;
   logic [SQ_W-1:0]  abs_sq_ff;

   // set state
   logic [VAL_W-1:0] peak_abs_ff;
   logic [VAL_W-1:0] peak_rel_ff;
   logic [SQ_W-1:0]  abs_sum_ff;
   logic [SQ_W-1:0]  rel_sum_ff;
   logic [CNT_W-1:0] count_ff;
   logic             sat_seen_ff;

   // result register
   logic             rsp_valid_ff;
   logic [VAL_W-1:0] out_max_abs_ff;
   logic [VAL_W-1:0] out_rms_abs_ff;
   logic [VAL_W-1:0] out_max_rel_ff;
   logic [VAL_W-1:0] out_rms_rel_ff;
   logic             out_sat_ff;

   logic [EXT_W-1:0] req_s_ext;
   logic [EXT_W-1:0] req_r_ext;
   logic [EXT_W-1:0] s_neg;
   logic [EXT_W-1:0] diff_neg;
   logic [SQ_W:0]    abs_total;
   logic [SQ_W:0]    rel_total;

   logic                  div_start;
   logic [VAL_W-1:0]      div_num;
   logic [VAL_W-1:0]      div_rem_init;
   logic [VAL_W-1:0]      div_quot;
   mrm_pkg::unit_status_type div_st;

   logic                  mul_start;
   logic [VAL_W-1:0]      mul_operand;
   logic [SQ_W-1:0]       mul_product;
   mrm_pkg::unit_status_type mul_st;

   logic                  mean_start;
   logic [SQ_W-1:0]       mean_abs;
   logic [SQ_W-1:0]       mean_rel;
   mrm_pkg::unit_status_type mean_abs_st;
   mrm_pkg::unit_status_type mean_rel_st;

   logic                  root_start;
   logic [VAL_W-1:0]      root_abs;
   logic [VAL_W-1:0]      root_rel;
   mrm_pkg::unit_status_type root_abs_st;
   mrm_pkg::unit_status_type root_rel_st;

   // only the low VALUE_WIDTH bits count, sign-extended
   assign req_s_ext = {{(EXT_W-VALUE_WIDTH){req_sample_value[VALUE_WIDTH-1]}},
                       req_sample_value[VALUE_WIDTH-1:0]};
   assign req_r_ext = {{(EXT_W-VALUE_WIDTH){req_reference_value[VALUE_WIDTH-1]}},
                       req_reference_value[VALUE_WIDTH-1:0]};

   assign s_neg    = '0 - s_ff;
   assign diff_neg = '0 - diff_ff;

   assign abs_total = {1'b0, abs_sum_ff} + {1'b0, abs_sq_ff};
   assign rel_total = {1'b0, rel_sum_ff} + {1'b0, mul_product};

   // |d| << 16 over max(|s|, 1.0): the top 16 dividend bits are below the
   // divisor, so they preload the remainder and only 32 steps remain
   assign div_start    = (state_ff == ST_DIV_GO);
   assign div_num      = {ad_ff[FRAC_W-1:0], {FRAC_W{1'b0}}};
   assign div_rem_init = {{FRAC_W{1'b0}}, ad_ff[VAL_W-1:FRAC_W]};

   // one multiplier squares |d| during the division, then r
   assign mul_start   = (state_ff == ST_DIV_GO) || (state_ff == ST_MUL_GO);
   assign mul_operand = (state_ff == ST_DIV_GO) ? ad_ff : rel_ff;

   assign mean_start = (state_ff == ST_MEAN_GO);
   assign root_start = (state_ff == ST_ROOT_GO);

   mrm_divider #(
      .NUM_W(VAL_W),
      .DEN_W(VAL_W)
   ) u_rel_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .numerator  (div_num),
      .rem_init   (div_rem_init),
      .denominator(den_ff),
      .quotient   (div_quot),
      .status     (div_st)
   );

   mrm_multiplier #(
      .W(VAL_W)
   ) u_square (
      .clock       (clock),
      .reset       (reset),
      .start       (mul_start),
      .multiplicand(mul_operand),
      .multiplier  (mul_operand),
      .product     (mul_product),
      .status      (mul_st)
   );

   mrm_divider #(
      .NUM_W(SQ_W),
      .DEN_W(CNT_W)
   ) u_mean_abs (
      .clock      (clock),
      .reset      (reset),
      .start      (mean_start),
      .numerator  (abs_sum_ff),
      .rem_init   ('0),
      .denominator(count_ff),
      .quotient   (mean_abs),
      .status     (mean_abs_st)
   );

   mrm_divider #(
      .NUM_W(SQ_W),
      .DEN_W(CNT_W)
   ) u_mean_rel (
      .clock      (clock),
      .reset      (reset),
      .start      (mean_start),
      .numerator  (rel_sum_ff),
      .rem_init   ('0),
      .denominator(count_ff),
      .quotient   (mean_rel),
      .status     (mean_rel_st)
   );

   mrm_isqrt #(
      .IN_W(SQ_W)
   ) u_root_abs (
      .clock   (clock),
      .reset   (reset),
      .start   (root_start),
      .radicand(mean_abs),
      .root    (root_abs),
      .status  (root_abs_st)
   );

   mrm_isqrt #(
      .IN_W(SQ_W)
   ) u_root_rel (
      .clock   (clock),
      .reset   (reset),
      .start   (root_start),
      .radicand(mean_rel),
      .root    (root_rel),
      .status  (root_rel_st)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         peak_abs_ff  <= '0;
         peak_rel_ff  <= '0;
         abs_sum_ff   <= '0;
         rel_sum_ff   <= '0;
         count_ff     <= '0;
         sat_seen_ff  <= 1'b0;
      end else begin
         // ST_EMIT drives the result valid itself
         if (rsp_valid_ff && rsp_ready && state_ff != ST_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  s_ff     <= req_s_ext;
                  r_ff     <= req_r_ext;
                  last_ff  <= req_last;
                  state_ff <= ST_DIFF;
               end
            end
            ST_DIFF: begin
               diff_ff   <= s_ff - r_ff;
               // |s| is at most 2^31 and fits the unsigned port width
               sabs_ff   <= s_ff[EXT_W-1] ? s_neg[VAL_W-1:0] : s_ff[VAL_W-1:0];
               s_zero_ff <= (s_ff == '0);
               state_ff  <= ST_ABS;
            end
            ST_ABS: begin
               ad_ff    <= diff_ff[EXT_W-1] ? diff_neg[VAL_W-1:0] : diff_ff[VAL_W-1:0];
               den_ff   <= (sabs_ff > mrm_pkg::ONE_Q16) ? sabs_ff : mrm_pkg::ONE_Q16;
               state_ff <= ST_DIV_GO;
            end
            ST_DIV_GO: begin
               state_ff <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               if (div_st.done) begin
                  abs_sq_ff <= mul_product;
                  rel_ff    <= s_zero_ff ? '0 : div_quot;
                  state_ff  <= ST_MUL_GO;
               end
            end
            ST_MUL_GO: begin
               state_ff <= ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
               if (mul_st.done) begin
                  state_ff <= ST_ACCUM;
               end
            end
            ST_ACCUM: begin
               if (ad_ff > peak_abs_ff) begin
                  peak_abs_ff <= ad_ff;
               end
               if (rel_ff > peak_rel_ff) begin
                  peak_rel_ff <= rel_ff;
               end
               abs_sum_ff <= abs_total[SQ_W] ? '1 : abs_total[SQ_W-1:0];
               rel_sum_ff <= rel_total[SQ_W] ? '1 : rel_total[SQ_W-1:0];
               if (abs_total[SQ_W] || rel_total[SQ_W]) begin
                  sat_seen_ff <= 1'b1;
               end
               // count sticks at the limit; later items still enter the sums
               if (count_ff < CNT_W'(MAX_ELEMENTS)) begin
                  count_ff <= count_ff + 1'b1;
               end
               state_ff <= last_ff ? ST_MEAN_GO : ST_IDLE;
            end
            ST_MEAN_GO: begin
               state_ff <= ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT: begin
               if (mean_abs_st.done) begin
                  state_ff <= ST_ROOT_GO;
               end
            end
            ST_ROOT_GO: begin
               state_ff <= ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT: begin
               if (root_abs_st.done) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               // hold until the previous result has been transferred
               if (!rsp_valid_ff || rsp_ready) begin
                  out_max_abs_ff <= peak_abs_ff;
                  out_rms_abs_ff <= root_abs;
                  out_max_rel_ff <= peak_rel_ff;
                  out_rms_rel_ff <= root_rel;
                  out_sat_ff     <= sat_seen_ff;
                  rsp_valid_ff   <= 1'b1;
                  peak_abs_ff    <= '0;
                  peak_rel_ff    <= '0;
                  abs_sum_ff     <= '0;
                  rel_sum_ff     <= '0;
                  count_ff       <= '0;
                  sat_seen_ff    <= 1'b0;
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_max_abs_error = out_max_abs_ff;
   assign rsp_rms_abs_error = out_rms_abs_ff;
   assign rsp_max_rel_error = out_max_rel_ff;
   assign rsp_rms_rel_error = out_rms_rel_ff;
   assign rsp_sum_saturated = out_sat_ff;

   // no unit may still be running when a new item can be taken
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!div_st.busy && !mul_st.busy && !mean_abs_st.busy
                     && !root_abs_st.busy))
      else $error("arithmetic unit busy while idle");

   // the |d| square must be finished when the division completes
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_WAIT && div_st.done) |-> !mul_st.busy)
      else $error("square not finished at end of division");

   // both mean dividers and both roots run in lockstep
   assert property (@(posedge clock) disable iff (reset)
      (mean_abs_st.done == mean_rel_st.done) && (root_abs_st.done == root_rel_st.done))
      else $error("paired units out of step");

   // a set is cleared on the same edge that presents its result
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (count_ff == '0 && !sat_seen_ff && abs_sum_ff == '0))
      else $error("set state not cleared with result");

   // a saturated set keeps at least one sum pinned at full scale
   assert property (@(posedge clock) disable iff (reset)
      sat_seen_ff |-> (abs_sum_ff == '1 || rel_sum_ff == '1))
      else $error("saturation flag without saturated sum");

endmodule

FILE: src/mrm_divider.sv
// ----------------------------------------------------------------------------
// mrm_divider
// Restoring unsigned divider, one quotient bit per cycle. The remainder can
// be preloaded, so leading dividend bits known to give zero are skipped.
// ----------------------------------------------------------------------------
module mrm_divider #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [NUM_W-1:0]         numerator,
   input  logic [DEN_W-1:0]         rem_init,
   input  logic [DEN_W-1:0]         denominator,
   output logic [NUM_W-1:0]         quotient,
   output mrm_pkg::unit_status_type status
);

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]  num_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;

   logic [DEN_W:0]    partial;
   logic [DEN_W:0]    trial_diff;
   logic              fits;

   // rem_init must be below the denominator
   assign partial    = {rem_ff, num_ff[NUM_W-1]};
   assign fits       = partial >= {1'b0, den_ff};
   assign trial_diff = partial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            num_ff  <= numerator;
            rem_ff  <= rem_init;
            den_ff  <= denominator;
            step_ff <= STEP_W'(NUM_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            // dividend bits shift out at the top, quotient bits in at the bottom
            num_ff  <= {num_ff[NUM_W-2:0], fits};
            rem_ff  <= fits ? trial_diff[DEN_W-1:0] : partial[DEN_W-1:0];
            step_ff <= step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient    = num_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

FILE: src/mrm_multiplier.sv
// ----------------------------------------------------------------------------
// mrm_multiplier
// Unsigned radix-4 serial multiplier, two multiplier bits per cycle, most
// significant digit first.
// ----------------------------------------------------------------------------
module mrm_multiplier #(
   parameter int W = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [W-1:0]             multiplicand,
   input  logic [W-1:0]             multiplier,
   output logic [2*W-1:0]           product,
   output mrm_pkg::unit_status_type status
);

   localparam int STEPS  = W / 2;
   localparam int STEP_W = $clog2(STEPS + 1);

   logic [W-1:0]      a_ff;
   logic [W+1:0]      a3_ff;
   logic [W-1:0]      b_ff;
   logic [2*W-1:0]    acc_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;

   logic [W+1:0]      pp;

   always_comb begin
      case (b_ff[W-1 -: 2])
         2'd0:    pp = '0;
         2'd1:    pp = {2'b00, a_ff};
         2'd2:    pp = {1'b0, a_ff, 1'b0};
         default: pp = a3_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            a_ff    <= multiplicand;
            a3_ff   <= (W+2)'(multiplicand) + (W+2)'({multiplicand, 1'b0});
            b_ff    <= multiplier;
            acc_ff  <= '0;
            step_ff <= STEP_W'(STEPS);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            // partial products of a prefix never exceed the final product
            acc_ff  <= {acc_ff[2*W-3:0], 2'b00} + (2*W)'(pp);
            b_ff    <= {b_ff[W-3:0], 2'b00};
            step_ff <= step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign product     = acc_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

FILE: src/mrm_isqrt.sv
// ----------------------------------------------------------------------------
// mrm_isqrt
// Serial integer square root, floor result, one root bit per cycle from
// two radicand bits.
// ----------------------------------------------------------------------------
module mrm_isqrt #(
   parameter int IN_W = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [IN_W-1:0]          radicand,
   output logic [IN_W/2-1:0]        root,
   output mrm_pkg::unit_status_type status
);

   localparam int OUT_W  = IN_W / 2;
   localparam int STEP_W = $clog2(OUT_W + 1);

   logic [IN_W-1:0]   val_ff;
   logic [OUT_W:0]    rem_ff;
   logic [OUT_W-1:0]  root_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;

   logic [OUT_W+2:0]  partial;
   logic [OUT_W+2:0]  trial;
   logic [OUT_W+2:0]  trial_diff;
   logic              fits;

   assign partial    = {rem_ff, val_ff[IN_W-1 -: 2]};
   assign trial      = (OUT_W+3)'({root_ff, 2'b01});
   assign fits       = partial >= trial;
   assign trial_diff = partial - trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            val_ff  <= radicand;
            rem_ff  <= '0;
            root_ff <= '0;
            step_ff <= STEP_W'(OUT_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            // remainder stays below 2*root+1, so OUT_W+1 bits hold it
            rem_ff  <= fits ? trial_diff[OUT_W:0] : partial[OUT_W:0];
            root_ff <= {root_ff[OUT_W-2:0], fits};
            val_ff  <= {val_ff[IN_W-3:0], 2'b00};
            step_ff <= step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign root        = root_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for max_rms_error_metrics. Streams sets of
// (sample, reference) pairs through the request channel, predicts the
// per-set max/RMS summary in a scoreboard and compares each response
// field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

localparam int SET_LIMIT = 1048576;
localparam int VALUE_BITS = 32;

typedef struct {
   logic [31:0] max_abs_error;
   logic [31:0] rms_abs_error;
   logic [31:0] max_rel_error;
   logic [31:0] rms_rel_error;
   logic        sum_saturated;
} set_summary_type;

class error_summary_model;
   logic [31:0]  peak_abs;
   logic [31:0]  peak_rel;
   logic [63:0]  abs_sq_sum;
   logic [63:0]  rel_sq_sum;
   int unsigned  count;
   bit           saturated;
   set_summary_type summaries_due[$];
   int unsigned  failures;

   function new();
      failures = 0;
      clear();
   endfunction

   function void clear();
      peak_abs   = '0;
      peak_rel   = '0;
      abs_sq_sum = '0;
      rel_sq_sum = '0;
      count      = 0;
      saturated  = 1'b0;
   endfunction

   function int pending();
      return summaries_due.size();
   endfunction

   // truncated square root, one result bit per trial
   static function logic [31:0] int_sqrt(logic [63:0] v);
      logic [31:0] root;
      logic [31:0] trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (32'd1 << b);
         if (64'(trial) * 64'(trial) <= v) root = trial;
      end
      return root;
   endfunction

   function logic [63:0] add_square(logic [63:0] acc, logic [63:0] sq);
      logic [64:0] total;
      total = {1'b0, acc} + {1'b0, sq};
      if (total[64]) begin
         saturated = 1'b1;
         return '1;
      end
      return total[63:0];
   endfunction

   function void note_pair(logic [31:0] samp, logic [31:0] refv, logic last_flag);
      longint       sv;
      longint       rv;
      longint       dv;
      logic [63:0]  ad;
      logic [63:0]  rel;
      logic [63:0]  den;
      set_summary_type res;
      sv = $signed(samp[VALUE_BITS-1:0]);
      rv = $signed(refv[VALUE_BITS-1:0]);
      dv = sv - rv;
      ad = (dv < 0) ? -dv : dv;
      rel = '0;
      // a zero sample gives no relative error; divisor floors at 1.0
      if (sv != 0) begin
         den = (sv < 0) ? -sv : sv;
         if (den < 64'(mrm_pkg::ONE_Q16)) den = 64'(mrm_pkg::ONE_Q16);
         rel = (ad << mrm_pkg::FRAC_W) / den;
      end
      if (ad > 64'(peak_abs)) peak_abs = ad[31:0];
      if (rel > 64'(peak_rel)) peak_rel = rel[31:0];
      abs_sq_sum = add_square(abs_sq_sum, ad * ad);
      rel_sq_sum = add_square(rel_sq_sum, rel * rel);
      if (count < SET_LIMIT) count++;
      if (!last_flag) return;
      res.max_abs_error = peak_abs;
      res.rms_abs_error = int_sqrt(abs_sq_sum / 64'(count));
      res.max_rel_error = peak_rel;
      res.rms_rel_error = int_sqrt(rel_sq_sum / 64'(count));
      res.sum_saturated = saturated;
      summaries_due.push_back(res);
      clear();
   endfunction

   function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         failures++;
      end
   endfunction

   function void check_summary(set_summary_type got);
      set_summary_type want;
      if (summaries_due.size() == 0) begin
         $error("response with no set pending");
         failures++;
         return;
      end
      want = summaries_due.pop_front();
      compare_field("max_abs_error", want.max_abs_error, got.max_abs_error);
      compare_field("rms_abs_error", want.rms_abs_error, got.rms_abs_error);
      compare_field("max_rel_error", want.max_rel_error, got.max_rel_error);
      compare_field("rms_rel_error", want.rms_rel_error, got.rms_rel_error);
      compare_field("sum_saturated", 32'(want.sum_saturated), 32'(got.sum_saturated));
   endfunction
endclass

module testbench;

   localparam int RANDOM_ITEMS = 880;
   localparam int HOLD_CYCLES  = 1200;
   localparam int STALL_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 300;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_sample_value;
   logic [31:0] req_reference_value;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_max_abs_error;
   logic [31:0] rsp_rms_abs_error;
   logic [31:0] rsp_max_rel_error;
   logic [31:0] rsp_rms_rel_error;
   logic        rsp_sum_saturated;

   error_summary_model summary = new();
   bit hold_request = 1'b0;
   int burst_left = 0;
   int quiet_cycles = 0;

   max_rms_error_metrics #(
      .MAX_ELEMENTS(SET_LIMIT),
      .VALUE_WIDTH (VALUE_BITS)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample_value   (req_sample_value),
      .req_reference_value(req_reference_value),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_max_abs_error  (rsp_max_abs_error),
      .rsp_rms_abs_error  (rsp_rms_abs_error),
      .rsp_max_rel_error  (rsp_max_rel_error),
      .rsp_rms_rel_error  (rsp_rms_rel_error),
      .rsp_sum_saturated  (rsp_sum_saturated)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [31:0] pick_value();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 7))
         0: return 32'h0;
         1, 2: return v;
         3: return $urandom_range(0, 32'h3FFFF) - 32'h20000;   // within +-2.0
         4: return $urandom_range(0, 32'h1FFFF) - 32'h10000;   // within +-1.0
         5: begin
            case ($urandom_range(0, 5))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'hFFFF_0000;
               3: return 32'h0001_0000;
               4: return 32'h0000_0001;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return {{8{v[23]}}, v[23:0]};
      endcase
   endfunction

   task automatic send_pair(input logic [31:0] samp, input logic [31:0] refv,
                            input logic last_flag);
      @(negedge clock);
      req_valid           <= 1'b1;
      req_sample_value    <= samp;
      req_reference_value <= refv;
      req_last            <= last_flag;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      summary.note_pair(samp, refv, last_flag);
   endtask

   task automatic send_random(input logic last_flag);
      logic [31:0] samp;
      logic [31:0] refv;
      samp = pick_value();
      // references mostly sit close to the sample, as in a real comparison
      if ($urandom_range(0, 3) == 0) refv = pick_value();
      else refv = samp + ($urandom_range(0, 32'h1FF) - 32'h100);
      send_pair(samp, refv, last_flag);
   endtask

   task automatic idle_for(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic pace();
      burst_left--;
      if (burst_left <= 0) begin
         if ($urandom_range(0, 4) == 0) burst_left = $urandom_range(60, 150);
         else burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 40));
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (summary.pending() != 0) @(posedge clock);
   endtask

   // receiver pacing: stretches of ready, random and stalled cycles
   initial begin : rsp_pacing
      int mode;
      int left;
      bit held;
      mode = 0;
      left = 0;
      held = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !held) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(1, 60);
         end
         left--;
         case (mode)
            0, 1: rsp_ready <= 1'b1;
            2: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin : rsp_watch
      set_summary_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         got.max_abs_error = rsp_max_abs_error;
         got.rms_abs_error = rsp_rms_abs_error;
         got.max_rel_error = rsp_max_rel_error;
         got.rms_rel_error = rsp_rms_rel_error;
         got.sum_saturated = rsp_sum_saturated;
         summary.check_summary(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("max_rms_error_metrics regression: fail");
      $finish;
   end

   initial begin : stimulus
      int sent;
      int set_len;
      bit paused;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_sample_value    = '0;
      req_reference_value = '0;
      req_last            = 1'b0;
      sent                = 0;
      paused              = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed sets
      send_pair(32'h0000_0000, 32'h0000_0000, 1'b1);
      send_pair(32'h0000_0000, 32'h0001_2345, 1'b1);      // zero sample: no relative error
      send_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);      // largest |d|, abs sum saturates
      send_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
      send_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
      send_pair(32'h0000_0100, 32'h0000_8000, 1'b1);      // |sample| below 1.0
      send_pair(32'hFFFF_0000, 32'h0000_0000, 1'b0);      // exactly -1.0
      send_pair(32'h0001_0000, 32'h0001_0000, 1'b1);      // equal values
      repeat (4) begin                                    // relative sum saturates
         send_pair(32'hFFFF_0000, 32'h7FFF_FFFF, 1'b0);
      end
      send_pair(32'h0003_0000, 32'hFFFD_0000, 1'b0);
      send_pair(32'h1234_5678, 32'h1234_5600, 1'b0);
      send_pair(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
      send_pair(32'h4000_0000, 32'hC000_0000, 1'b1);
      wait_drained();

      // receiver holds off while short sets keep coming
      hold_request = 1'b1;
      for (int k = 0; k < 12; k++) send_random(k % 3 == 2);
      wait_drained();

      burst_left = $urandom_range(1, 24);
      while (sent < RANDOM_ITEMS) begin
         if (!paused && sent >= RANDOM_ITEMS / 2) begin
            wait_drained();
            paused = 1'b1;
         end
         if ($urandom_range(0, 7) == 0) set_len = $urandom_range(9, 40);
         else set_len = $urandom_range(1, 8);
         for (int k = 0; k < set_len; k++) begin
            send_random(k == set_len - 1);
            sent++;
            pace();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (summary.failures == 0) $display("max_rms_error_metrics regression: pass");
      else $display("max_rms_error_metrics regression: fail");
      $finish;
   end

endmodule

FILE: files.f
src/mrm_pkg.sv
src/mrm_divider.sv
src/mrm_multiplier.sv
src/mrm_isqrt.sv
src/max_rms_error_metrics.sv
tb/testbench.sv
